@@ hdl/mrr_pkg.sv @@
// Shared types and constants for the read response receiver.
`timescale 1ns / 1ps

package mrr_pkg;

    // Longest frame accepted; the byte position field caps it at 128 as well.
    localparam int MAX_FRAME_BYTES = 128;
    localparam int FRAME_LIMIT     = (MAX_FRAME_BYTES < 128) ? MAX_FRAME_BYTES : 128;

    localparam logic [15:0] CRC_INIT  = 16'hFFFF;
    localparam logic [15:0] CRC_POLY  = 16'hA001;
    localparam logic [7:0]  FUNC_READ = 8'h03;

    // Configuration register indexes
    localparam logic [1:0] REG_EXPECTED  = 2'd0;
    localparam logic [1:0] REG_DEVICE    = 2'd1;
    localparam logic [1:0] REG_ALTERNATE = 2'd2;

    typedef enum logic [2:0] {
        ST_RECEIVING = 3'd0,
        ST_GOOD      = 3'd1,
        ST_BAD_ADDR  = 3'd2,
        ST_BAD_FUNC  = 3'd3,
        ST_BAD_COUNT = 3'd4,
        ST_CRC_BAD   = 3'd5,
        ST_IGNORED   = 3'd6
    } status_t;

    typedef struct packed {
        logic [5:0] expected_registers;
        logic [7:0] device_address;
        logic [7:0] alternate_address;
    } cfg_t;

    // Classified byte as it travels from front to back
    typedef struct packed {
        logic [7:0] rx_byte;
        logic       frame_start;
        logic       addr_ok;
        logic       func_ok;
        logic       count_match;
    } item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic        frame_done;
        logic        word_valid;
        logic [15:0] reg_word;
        logic [5:0]  word_index;
        logic [6:0]  byte_position;
    } res_t;

endpackage

@@ hdl/modbus_read_response_receiver.sv @@
// Top level of the Modbus function-3 read response receiver.
`timescale 1ns / 1ps
//
// Usage:
//   Bytes enter through a queue-style port: a transfer happens at a clock edge with
//   push high and full low. rx_byte carries the byte; frame_start high clears the
//   frame state before that byte so it is taken as the address byte.
//   Each byte yields exactly one result, read from a queue-style port: while empty
//   is low the oldest result sits on status/frame_done/word_valid/reg_word/
//   word_index/byte_position, and pop high transfers it.
//   A pushed byte is registered in the input queue; its result is then registered
//   in the result queue and shows on the result ports. Throughput: one byte per
//   cycle while the result queue has room, paced by the combinational CRC update.
//   A two-entry queue after the byte classifier and another in front of the result
//   port let either side stall; when pop stays low the result queue fills, the back
//   stage halts, and full rises once the input queue holds two bytes.
//   Reset empties both queues, reopens the frame (CRC FFFF, position 0) and loads
//   the registers with 34 registers, address FF and alternate address 01.
//   Configuration (cfg_write/cfg_index/cfg_data) takes effect at once; write it only
//   while no byte is in flight. Unused indexes are dropped.

module modbus_read_response_receiver (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  rx_byte,
    input  logic        frame_start,
    output logic        empty,
    input  logic        pop,
    output logic [2:0]  status,
    output logic        frame_done,
    output logic        word_valid,
    output logic [15:0] reg_word,
    output logic [5:0]  word_index,
    output logic [6:0]  byte_position
);

    mrr_pkg::cfg_t  cfg_reg;
    mrr_pkg::item_t front_item, back_item;
    mrr_pkg::res_t  back_res, out_res;
    logic           item_empty, item_pop;
    logic           res_full, res_push;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.expected_registers <= 6'd34;
            cfg_reg.device_address     <= 8'hFF;
            cfg_reg.alternate_address  <= 8'h01;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                mrr_pkg::REG_EXPECTED:  cfg_reg.expected_registers <= cfg_data[5:0];
                mrr_pkg::REG_DEVICE:    cfg_reg.device_address     <= cfg_data;
                mrr_pkg::REG_ALTERNATE: cfg_reg.alternate_address  <= cfg_data;
                default:                ;
            endcase
        end
    end

    mrr_front u_front (
        .cfg         (cfg_reg),
        .rx_byte     (rx_byte),
        .frame_start (frame_start),
        .item        (front_item)
    );

    // Queue between classifier and frame engine
    mrr_fifo #(
        .WIDTH ($bits(mrr_pkg::item_t)),
        .DEPTH (2)
    ) u_item_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_data (front_item),
        .full    (full),
        .pop     (item_pop),
        .rd_data (back_item),
        .empty   (item_empty)
    );

    mrr_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .item     (back_item),
        .in_empty (item_empty),
        .in_pop   (item_pop),
        .out_full (res_full),
        .out_push (res_push),
        .res      (back_res)
    );

    // Result queue: holds finished results while the receiver stalls
    mrr_fifo #(
        .WIDTH ($bits(mrr_pkg::res_t)),
        .DEPTH (2)
    ) u_res_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (res_push),
        .wr_data (back_res),
        .full    (res_full),
        .pop     (pop),
        .rd_data (out_res),
        .empty   (empty)
    );

    assign status        = out_res.status;
    assign frame_done    = out_res.frame_done;
    assign word_valid    = out_res.word_valid;
    assign reg_word      = out_res.reg_word;
    assign word_index    = out_res.word_index;
    assign byte_position = out_res.byte_position;

endmodule

@@ hdl/mrr_fifo.sv @@
// Small register FIFO used between the receiver stages.
`timescale 1ns / 1ps

module mrr_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

@@ hdl/mrr_front.sv @@
// Front stage: classify each received byte against the configuration.
`timescale 1ns / 1ps

module mrr_front (
    input  mrr_pkg::cfg_t  cfg,
    input  logic [7:0]     rx_byte,
    input  logic           frame_start,
    output mrr_pkg::item_t item
);

    always_comb
    begin
        item.rx_byte     = rx_byte;
        item.frame_start = frame_start;
        item.addr_ok     = (rx_byte == cfg.device_address)
                        || (rx_byte == cfg.alternate_address);
        item.func_ok     = (rx_byte == mrr_pkg::FUNC_READ);
        item.count_match = (rx_byte == {1'b0, cfg.expected_registers, 1'b0});
    end

endmodule

@@ hdl/mrr_back.sv @@
// Back stage: frame state, CRC and result generation.
`timescale 1ns / 1ps

module mrr_back (
    input  logic           clk,
    input  logic           rst_n,
    input  mrr_pkg::cfg_t  cfg,
    input  mrr_pkg::item_t item,
    input  logic           in_empty,
    output logic           in_pop,
    input  logic           out_full,
    output logic           out_push,
    output mrr_pkg::res_t  res
);

    logic [6:0]  byte_count_reg, byte_count_next;
    logic [15:0] crc_reg, crc_next;
    logic        ended_reg, ended_next;
    logic [7:0]  high_reg, high_next;
    logic [7:0]  low_reg, low_next;

    logic [6:0]  bc_eff;
    logic [15:0] crc_eff;
    logic        ended_eff;
    logic [7:0]  high_eff, low_eff;
    logic [7:0]  flen, pos8, pld;
    logic        fire, end_frame, feed;
    logic [15:0] rx_crc;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++)
        begin
            c = c[0] ? ((c >> 1) ^ mrr_pkg::CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    assign fire     = !in_empty && !out_full;
    assign in_pop   = fire;
    assign out_push = fire;

    always_comb
    begin
        // Start flag clears the frame before this byte is looked at
        bc_eff    = item.frame_start ? '0 : byte_count_reg;
        crc_eff   = item.frame_start ? mrr_pkg::CRC_INIT : crc_reg;
        ended_eff = item.frame_start ? 1'b0 : ended_reg;
        high_eff  = item.frame_start ? '0 : high_reg;
        low_eff   = item.frame_start ? '0 : low_reg;

        flen   = {1'b0, cfg.expected_registers, 1'b0} + 8'd5;
        pos8   = {1'b0, bc_eff};
        pld    = pos8 - 8'd3;
        rx_crc = {item.rx_byte, low_eff};

        res               = '0;
        res.status        = mrr_pkg::ST_RECEIVING;
        res.byte_position = bc_eff;
        end_frame         = 1'b0;
        feed              = 1'b0;

        byte_count_next = bc_eff;
        crc_next        = crc_eff;
        ended_next      = ended_eff;
        high_next       = high_eff;
        low_next        = low_eff;

        if (ended_eff)
        begin
            res.status = mrr_pkg::ST_IGNORED;
        end
        else
        begin
            if (pos8 == 8'd0)
            begin
                if (!item.addr_ok)
                begin
                    res.status = mrr_pkg::ST_BAD_ADDR;
                    end_frame  = 1'b1;
                end
                else
                begin
                    feed = 1'b1;
                end
            end
            else if (pos8 == 8'd1)
            begin
                if (!item.func_ok)
                begin
                    res.status = mrr_pkg::ST_BAD_FUNC;
                    end_frame  = 1'b1;
                end
                else
                begin
                    feed = 1'b1;
                end
            end
            else if (pos8 == 8'd2)
            begin
                if (!item.count_match || ({1'b0, flen} > 9'(mrr_pkg::FRAME_LIMIT)))
                begin
                    res.status = mrr_pkg::ST_BAD_COUNT;
                    end_frame  = 1'b1;
                end
                else
                begin
                    feed = 1'b1;
                end
            end
            else if (pos8 >= flen)
            begin
                // Register count shrank under a running frame
                res.status = mrr_pkg::ST_BAD_COUNT;
                end_frame  = 1'b1;
            end
            else if ((pos8 + 8'd2) < flen)
            begin
                feed = 1'b1;
                if (!pld[0])
                begin
                    high_next = item.rx_byte;
                end
                else
                begin
                    res.word_valid = 1'b1;
                    res.reg_word   = {high_eff, item.rx_byte};
                    res.word_index = pld[6:1];
                end
            end
            else if ((pos8 + 8'd2) == flen)
            begin
                low_next = item.rx_byte;
            end
            else
            begin
                res.status = (rx_crc == crc_eff) ? mrr_pkg::ST_GOOD : mrr_pkg::ST_CRC_BAD;
                end_frame  = 1'b1;
            end

            if (feed)
            begin
                crc_next = crc_byte(crc_eff, item.rx_byte);
            end
            if (end_frame)
            begin
                ended_next     = 1'b1;
                res.frame_done = 1'b1;
            end
            byte_count_next = bc_eff + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg <= '0;
            crc_reg        <= mrr_pkg::CRC_INIT;
            ended_reg      <= 1'b0;
            high_reg       <= '0;
            low_reg        <= '0;
        end
        else if (fire)
        begin
            byte_count_reg <= byte_count_next;
            crc_reg        <= crc_next;
            ended_reg      <= ended_next;
            high_reg       <= high_next;
            low_reg        <= low_next;
        end
    end

endmodule

@@ hdl/mrr_checker.sv @@
// Port-level checks for the read response receiver, bound to the top level.
`timescale 1ns / 1ps

module mrr_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        cfg_write,
    input logic [1:0]  cfg_index,
    input logic [7:0]  cfg_data,
    input logic        push,
    input logic        full,
    input logic [7:0]  rx_byte,
    input logic        frame_start,
    input logic        empty,
    input logic        pop,
    input logic [2:0]  status,
    input logic        frame_done,
    input logic        word_valid,
    input logic [15:0] reg_word,
    input logic [5:0]  word_index,
    input logic [6:0]  byte_position
);

    // Nothing is waiting right after reset
    a_empty_after_reset: assert property (@(posedge clk) $past(!rst_n) |-> empty)
        else $error("result queue not empty after reset");

    // A frame end carries a final verdict
    a_done_status: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && frame_done) |->
            (status != mrr_pkg::ST_RECEIVING && status != mrr_pkg::ST_IGNORED))
        else $error("frame_done with non-final status");

    // Words only appear mid-frame
    a_word_mid_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && word_valid) |-> (status == mrr_pkg::ST_RECEIVING && !frame_done))
        else $error("word emitted outside an open frame");

    // Without a word the word fields stay zero
    a_word_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !word_valid) |-> (reg_word == 16'h0000 && word_index == 6'd0))
        else $error("word fields set without word_valid");

    // A waiting result holds while the receiver stalls
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(status) && $stable(reg_word)
            && $stable(byte_position)))
        else $error("stalled result changed");

endmodule

bind modbus_read_response_receiver mrr_checker u_mrr_checker (.*);
